// File: rtl/core/tepe_pkg.sv
// shared types, constants and helpers of the trace event packet encoder
`timescale 1ns / 1ps
package tepe_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned SeqW    = 32;
	localparam int unsigned CmdW    = 2;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 4;
	localparam int unsigned SeqLenW = 3;
	localparam int unsigned EvLenW  = 5;
	localparam int unsigned PktLenW = 6;
	localparam int unsigned TypeW   = 3;
	localparam int unsigned QDepth  = 2;
	localparam int unsigned QPtrW   = 1;
	localparam int unsigned QCntW   = 2;

	typedef enum logic [CmdW-1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_END     = 2'd1,
		CMD_COUNTER = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	localparam logic [TypeW-1:0] TYPE_BEGIN   = 3'd1;
	localparam logic [TypeW-1:0] TYPE_END     = 3'd2;
	localparam logic [TypeW-1:0] TYPE_COUNTER = 3'd4;

	localparam logic [ByteW-1:0] TAG_PACKET = 8'h0A;
	localparam logic [ByteW-1:0] TAG_TS     = 8'h40;
	localparam logic [ByteW-1:0] TAG_SEQ    = 8'h50;
	localparam logic [ByteW-1:0] TAG_EVENT  = 8'h5A;
	localparam logic [ByteW-1:0] TAG_TYPE   = 8'h48;
	localparam logic [ByteW-1:0] TAG_TRACK  = 8'h58;
	localparam logic [ByteW-1:0] TAG_CNT_LO = 8'hF0;
	localparam logic [ByteW-1:0] TAG_CNT_HI = 8'h01;

	typedef struct packed {
		logic                 is_cnt;
		logic [TypeW-1:0]     ev_type;
		logic [WordW-1:0]     ts;
		logic [WordW-1:0]     track;
		logic [WordW-1:0]     cval;
		logic [LenW-1:0]      ts_len;
		logic [SeqLenW-1:0]   seq_len;
		logic [LenW-1:0]      trk_len;
		logic [LenW-1:0]      cv_len;
		logic [EvLenW-1:0]    ev_len;
		logic [PktLenW-1:0]   pkt_len;
	} tepe_desc_t;

	typedef enum logic [3:0] {
		PH_TAG_PKT,
		PH_PKT_LEN,
		PH_TAG_TS,
		PH_TS,
		PH_TAG_SEQ,
		PH_SEQ,
		PH_TAG_EV,
		PH_EV_LEN,
		PH_TAG_TYPE,
		PH_TYPE,
		PH_TAG_TRK,
		PH_TRK,
		PH_TAG_CNT0,
		PH_TAG_CNT1,
		PH_CNT
	} phase_t;

	// number of 7-bit groups up to the highest nonzero one
	function automatic logic [LenW-1:0] varint_len(input logic [WordW-1:0] v);
		logic [LenW-1:0] n;
		n = 4'd1;
		for (int g = 1; g < 10; g++) begin
			if ((v >> (7 * g)) != '0) n = LenW'(g + 1);
		end
		return n;
	endfunction

endpackage

// File: rtl/core/tepe_if.sv
// request channels of the trace event packet encoder
`timescale 1ns / 1ps
interface tepe_in_if;
	import tepe_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CmdW-1:0]         cmd;
	logic [WordW-1:0]        timestamp_ns;
	logic [WordW-1:0]        track_uuid;
	logic signed [WordW-1:0] counter_value;
	modport source (output valid, cmd, timestamp_ns, track_uuid, counter_value, input ready);
	modport sink (input valid, cmd, timestamp_ns, track_uuid, counter_value, output ready);
endinterface

interface tepe_out_if;
	import tepe_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] out_byte;
	logic             last;
	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

interface tepe_cfg_if;
	import tepe_pkg::*;
	logic            valid;
	logic            ready;
	logic [SeqW-1:0] sequence_id;
	modport source (output valid, sequence_id, input ready);
	modport sink (input valid, sequence_id, output ready);
endinterface

// File: rtl/core/tepe_front.sv
// front end: accepts events, classifies them and sizes every field of the record
`timescale 1ns / 1ps
module tepe_front (
	tepe_in_if.sink                        evt,
	input  logic [tepe_pkg::SeqW-1:0]      seq_id,
	input  logic                           q_full,
	output logic                           push,
	output tepe_pkg::tepe_desc_t           push_desc
);
	import tepe_pkg::*;

	logic is_cnt;

	assign evt.ready = !q_full;

	always_comb begin
		is_cnt = (cmd_t'(evt.cmd) == CMD_COUNTER);
		push   = evt.valid && !q_full && (cmd_t'(evt.cmd) != CMD_UNUSED);

		push_desc.is_cnt = is_cnt;
		case (cmd_t'(evt.cmd))
			CMD_BEGIN: begin
				push_desc.ev_type = TYPE_BEGIN;
			end
			CMD_END: begin
				push_desc.ev_type = TYPE_END;
			end
			default: begin
				push_desc.ev_type = TYPE_COUNTER;
			end
		endcase
		push_desc.ts      = evt.timestamp_ns;
		push_desc.track   = evt.track_uuid;
		push_desc.cval    = evt.counter_value;
		push_desc.ts_len  = varint_len(evt.timestamp_ns);
		push_desc.seq_len = SeqLenW'(varint_len({{(WordW - SeqW){1'b0}}, seq_id}));
		push_desc.trk_len = varint_len(evt.track_uuid);
		push_desc.cv_len  = varint_len(evt.counter_value);
		// type tag, type byte, track tag, track varint, optional counter part
		push_desc.ev_len  = EvLenW'(3) + EvLenW'(push_desc.trk_len)
			+ (is_cnt ? EvLenW'(2) + EvLenW'(push_desc.cv_len) : EvLenW'(0));
		// three tags, event length byte, then the varints and the event
		push_desc.pkt_len = PktLenW'(4) + PktLenW'(push_desc.ts_len)
			+ PktLenW'(push_desc.seq_len) + PktLenW'(push_desc.ev_len);
	end

endmodule

// File: rtl/core/tepe_queue.sv
// two-entry queue of sized events between front and back
`timescale 1ns / 1ps
module tepe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tepe_pkg::tepe_desc_t  push_desc,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output tepe_pkg::tepe_desc_t  head
);
	import tepe_pkg::*;

	tepe_desc_t       entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full  = (cnt_q == QCntW'(QDepth));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/tepe_back.sv
// back end: walks the record field by field and sends one byte per cycle while rec.ready is high
`timescale 1ns / 1ps
module tepe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tepe_pkg::SeqW-1:0]  seq_id,
	input  logic                       head_valid,
	input  tepe_pkg::tepe_desc_t       head,
	output logic                       pop,
	tepe_out_if.source                 rec
);
	import tepe_pkg::*;

	phase_t           phase_q, phase_d;
	logic [WordW-1:0] val_q, val_d;
	logic [LenW-1:0]  cnt_q, cnt_d;
	logic [ByteW-1:0] out_byte_q, byte_d;
	logic             last_q, last_d;
	logic             out_valid_q;
	logic             emit;
	logic             vdone;
	logic [ByteW-1:0] vbyte;

	assign rec.valid    = out_valid_q;
	assign rec.out_byte = out_byte_q;
	assign rec.last     = last_q;

	always_comb begin
		emit    = head_valid && (!out_valid_q || rec.ready);
		vdone   = (cnt_q == LenW'(1));
		vbyte   = {!vdone, val_q[6:0]};
		phase_d = phase_q;
		val_d   = val_q;
		cnt_d   = cnt_q;
		byte_d  = '0;
		last_d  = 1'b0;
		if (emit) begin
			case (phase_q)
				PH_TAG_PKT: begin
					byte_d  = TAG_PACKET;
					phase_d = PH_PKT_LEN;
				end
				PH_PKT_LEN: begin
					byte_d  = ByteW'(head.pkt_len);
					phase_d = PH_TAG_TS;
				end
				PH_TAG_TS: begin
					byte_d  = TAG_TS;
					val_d   = head.ts;
					cnt_d   = head.ts_len;
					phase_d = PH_TS;
				end
				PH_TS: begin
					byte_d = vbyte;
					val_d  = val_q >> 7;
					cnt_d  = cnt_q - 1'b1;
					if (vdone) phase_d = PH_TAG_SEQ;
				end
				PH_TAG_SEQ: begin
					byte_d  = TAG_SEQ;
					val_d   = {{(WordW - SeqW){1'b0}}, seq_id};
					cnt_d   = LenW'(head.seq_len);
					phase_d = PH_SEQ;
				end
				PH_SEQ: begin
					byte_d = vbyte;
					val_d  = val_q >> 7;
					cnt_d  = cnt_q - 1'b1;
					if (vdone) phase_d = PH_TAG_EV;
				end
				PH_TAG_EV: begin
					byte_d  = TAG_EVENT;
					phase_d = PH_EV_LEN;
				end
				PH_EV_LEN: begin
					byte_d  = ByteW'(head.ev_len);
					phase_d = PH_TAG_TYPE;
				end
				PH_TAG_TYPE: begin
					byte_d  = TAG_TYPE;
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					byte_d  = ByteW'(head.ev_type);
					phase_d = PH_TAG_TRK;
				end
				PH_TAG_TRK: begin
					byte_d  = TAG_TRACK;
					val_d   = head.track;
					cnt_d   = head.trk_len;
					phase_d = PH_TRK;
				end
				PH_TRK: begin
					byte_d = vbyte;
					val_d  = val_q >> 7;
					cnt_d  = cnt_q - 1'b1;
					if (vdone) begin
						if (head.is_cnt) begin
							phase_d = PH_TAG_CNT0;
						end else begin
							last_d  = 1'b1;
							phase_d = PH_TAG_PKT;
						end
					end
				end
				PH_TAG_CNT0: begin
					byte_d  = TAG_CNT_LO;
					phase_d = PH_TAG_CNT1;
				end
				PH_TAG_CNT1: begin
					byte_d  = TAG_CNT_HI;
					val_d   = head.cval;
					cnt_d   = head.cv_len;
					phase_d = PH_CNT;
				end
				PH_CNT: begin
					byte_d = vbyte;
					val_d  = val_q >> 7;
					cnt_d  = cnt_q - 1'b1;
					if (vdone) begin
						last_d  = 1'b1;
						phase_d = PH_TAG_PKT;
					end
				end
				default: begin
					phase_d = PH_TAG_PKT;
				end
			endcase
		end
		pop = emit && last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG_PKT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (emit) begin
			out_byte_q <= byte_d;
			last_q     <= last_d;
		end
	end

endmodule

// File: rtl/core/trace_event_packet_encoder.sv
// top level of the trace event packet encoder
// Each accepted event (slice begin, slice end or counter) leaves as one length-delimited
// trace packet record of 12 to 46 bytes on rec, one byte per cycle while rec.ready is high,
// with last set on the final byte. The byte sequencer in the back end sets the pace: the
// record goes out byte by byte, and the next record starts once the previous last byte
// has been sent. The front end sizes all varints on acceptance and
// takes new events while the two-entry queue has room; the event being sent holds one
// entry until its last byte, so one more event waits behind it. Events with command
// code 3 are accepted and produce nothing. The sequence id register is written on cfg
// and should only change while no record is pending.
`timescale 1ns / 1ps
module trace_event_packet_encoder (
	input  logic        clk,
	input  logic        arst_n,
	tepe_in_if.sink     evt,
	tepe_out_if.source  rec,
	tepe_cfg_if.sink    cfg
);
	import tepe_pkg::*;

	logic [SeqW-1:0] seq_id_q;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;
	tepe_desc_t      push_desc;
	tepe_desc_t      head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_id_q <= '0;
		end else if (cfg.valid) begin
			seq_id_q <= cfg.sequence_id;
		end
	end

	tepe_front u_front (
		.evt       (evt),
		.seq_id    (seq_id_q),
		.q_full    (q_full),
		.push      (q_push),
		.push_desc (push_desc)
	);

	tepe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head)
	);

	tepe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seq_id     (seq_id_q),
		.head_valid (!q_empty),
		.head       (head),
		.pop        (q_pop),
		.rec        (rec)
	);

`ifndef SYNTHESIS
	a_pop_sends_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> rec.valid && rec.last)
		else $error("record retired without a last byte");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("queued event lost");
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule

// File: tb/trace_event_packet_encoder_tb.sv
// testbench of the trace event packet encoder: random events against a byte-level record predictor
`timescale 1ns / 1ps
module trace_event_packet_encoder_tb;
	import tepe_pkg::*;

	typedef struct {
		logic [ByteW-1:0] data;
		logic             last;
	} rec_byte_t;

	class record_scoreboard;
		rec_byte_t        expected_bytes[$];
		logic [ByteW-1:0] build[$];
		logic [SeqW-1:0]  seq_id;
		int               errors;

		function new();
			seq_id = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		task report(input string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void add_byte(input logic [ByteW-1:0] b);
			build.insert(build.size(), b);
		endfunction

		function int group_count(input logic [WordW-1:0] v);
			int n;
			n = 1;
			while (v >= 64'h80) begin
				v = v >> 7;
				n++;
			end
			return n;
		endfunction

		function void append_leb(input logic [WordW-1:0] v);
			while (v >= 64'h80) begin
				add_byte((v[7:0] & 8'h7F) | 8'h80);
				v = v >> 7;
			end
			add_byte(v[7:0]);
		endfunction

		// one accepted request becomes the full byte sequence of its record; command code 3 adds nothing
		function void note_event(input cmd_t cmd, input logic [WordW-1:0] ts,
				input logic [WordW-1:0] trk, input logic [WordW-1:0] cval);
			logic [TypeW-1:0] ev_type;
			bit               is_cnt;
			int               ev_len;
			int               pkt_len;
			rec_byte_t        rb;
			if (cmd == CMD_UNUSED) return;
			is_cnt  = (cmd == CMD_COUNTER);
			ev_type = (cmd == CMD_BEGIN) ? TYPE_BEGIN : (cmd == CMD_END) ? TYPE_END : TYPE_COUNTER;
			ev_len  = 2 + group_count(WordW'(ev_type)) + group_count(trk);
			if (is_cnt) ev_len += 2 + group_count(cval);
			pkt_len = 3 + group_count(ts) + group_count(WordW'(seq_id))
				+ group_count(WordW'(ev_len)) + ev_len;
			build.delete();
			add_byte(TAG_PACKET);
			append_leb(WordW'(pkt_len));
			add_byte(TAG_TS);
			append_leb(ts);
			add_byte(TAG_SEQ);
			append_leb(WordW'(seq_id));
			add_byte(TAG_EVENT);
			append_leb(WordW'(ev_len));
			add_byte(TAG_TYPE);
			append_leb(WordW'(ev_type));
			add_byte(TAG_TRACK);
			append_leb(trk);
			if (is_cnt) begin
				add_byte(TAG_CNT_LO);
				add_byte(TAG_CNT_HI);
				append_leb(cval);
			end
			foreach (build[i]) begin
				rb.data = build[i];
				rb.last = (i == build.size() - 1);
				expected_bytes.insert(expected_bytes.size(), rb);
			end
		endfunction

		task check_byte(input logic [ByteW-1:0] data, input logic last);
			rec_byte_t rb;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b", data, last));
				return;
			end
			rb = expected_bytes.pop_front();
			if (data !== rb.data)
				report($sformatf("out_byte %02h, expected %02h", data, rb.data));
			if (last !== rb.last)
				report($sformatf("last %0b, expected %0b", last, rb.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	int   stall_left;
	record_scoreboard sb;

	tepe_in_if  evt ();
	tepe_out_if rec ();
	tepe_cfg_if cfg ();

	trace_event_packet_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt.sink),
		.rec    (rec.source),
		.cfg    (cfg.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// output side back-pressure
	initial begin
		rec.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rec.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				rec.ready <= 1'b0;
			end else begin
				rec.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rec.valid && rec.ready) sb.check_byte(rec.out_byte, rec.last);
	end

	function automatic logic [WordW-1:0] rand_word();
		int               nb;
		logic [WordW-1:0] v;
		nb = $urandom_range(0, 64);
		v  = {$urandom, $urandom};
		if (nb == 0) return '0;
		return v >> (64 - nb);
	endfunction

	task automatic send_event(input cmd_t cmd, input logic [WordW-1:0] ts,
			input logic [WordW-1:0] trk, input logic [WordW-1:0] cval);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			evt.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		evt.valid         <= 1'b1;
		evt.cmd           <= cmd;
		evt.timestamp_ns  <= ts;
		evt.track_uuid    <= trk;
		evt.counter_value <= cval;
		do @(posedge clk); while (!evt.ready);
		sb.note_event(cmd, ts, trk, cval);
		@(negedge clk);
	endtask

	task automatic drain();
		evt.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_seq(input logic [SeqW-1:0] v);
		cfg.valid       <= 1'b1;
		cfg.sequence_id <= v;
		do @(posedge clk); while (!cfg.ready);
		sb.seq_id = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_events(input int count);
		int   done;
		cmd_t cmd;
		logic [WordW-1:0] cval;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 19) == 0) cmd = CMD_UNUSED;
			else cmd = cmd_t'($urandom_range(0, 2));
			cval = rand_word();
			if ($urandom_range(0, 1) == 1) cval = -cval;
			send_event(cmd, rand_word(), rand_word(), cval);
			if (cmd != CMD_UNUSED) done++;
		end
	endtask

	initial begin
		logic [SeqW-1:0] seq_set[5];
		sb = new();
		idle_on = 1'b1;
		arst_n = 1'b0;
		evt.valid <= 1'b0;
		evt.cmd <= CMD_BEGIN;
		evt.timestamp_ns <= '0;
		evt.track_uuid <= '0;
		evt.counter_value <= '0;
		cfg.valid <= 1'b0;
		cfg.sequence_id <= '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed requests with the reset sequence id
		send_event(CMD_BEGIN, '0, '0, '0);
		send_event(CMD_END, '1, '1, '0);
		send_event(CMD_COUNTER, 64'd1, 64'd2, '0);
		send_event(CMD_COUNTER, 64'd127, 64'd128, 64'h7FFF_FFFF_FFFF_FFFF);
		send_event(CMD_COUNTER, 64'd128, 64'd127, 64'h8000_0000_0000_0000);
		send_event(CMD_COUNTER, 64'd16383, 64'd16384, '1);
		send_event(CMD_COUNTER, 64'd16384, 64'd16383, 64'd127);
		send_event(CMD_COUNTER, 64'd5, 64'd6, 64'd128);
		send_event(CMD_BEGIN, 64'd1000, 64'd7, 64'hDEAD_BEEF_0000_0001);
		send_event(CMD_END, 64'd2000, 64'd7, '1);
		send_event(CMD_UNUSED, '1, '1, '1);
		send_event(CMD_BEGIN, 64'h0100_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
		send_event(CMD_UNUSED, '0, '0, '0);
		send_event(CMD_END, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		drain();

		write_seq('1);
		send_event(CMD_COUNTER, '1, '1, 64'h8000_0000_0000_0000);
		send_event(CMD_COUNTER, '1, '1, '1);
		send_event(CMD_BEGIN, '0, '0, '0);
		send_event(CMD_END, '1, '0, '0);
		drain();

		seq_set[0] = 32'd127;
		seq_set[1] = 32'd128;
		seq_set[2] = $urandom;
		seq_set[3] = '0;
		seq_set[4] = '1;
		for (int p = 0; p < 5; p++) begin
			write_seq(seq_set[p]);
			if (p == 4) idle_on = 1'b0;
			random_events(30);
			drain();
		end

		if (sb.pending() != 0) sb.report($sformatf("%0d bytes never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
